@@ hw/rtl/lsv_pkg.sv @@
// lsv_pkg: shared types and codes for the 3x3 linear solver.
// No dependencies.
package lsv_pkg;

  typedef logic [1:0] lsv_status_t;

  localparam lsv_status_t ST_OK       = 2'd0;
  localparam lsv_status_t ST_SINGULAR = 2'd1;
  localparam lsv_status_t ST_SAT      = 2'd2;

  // side information that travels with an item through the divider
  typedef struct packed {
    logic       zero;  // determinant is exactly zero
    logic [2:0] neg;   // quotient sign per component
  } lsv_tag_t;

endpackage

@@ hw/rtl/lsv_div_step.sv @@
// lsv_div_step: one registered step of the restoring divider, one quotient bit
// for each of the three components. Depends on lsv_pkg.
module lsv_div_step import lsv_pkg::*; #(
  parameter int DataWidth = 32,
  parameter int RemWidth  = 155,
  parameter int Shift     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  lsv_tag_t            tag_i,
  input  logic [RemWidth-1:0] den_i,
  input  logic [RemWidth-1:0] rem_i [3],
  input  logic [DataWidth:0]  quo_i [3],
  output logic                valid_o,
  output lsv_tag_t            tag_o,
  output logic [RemWidth-1:0] den_o,
  output logic [RemWidth-1:0] rem_o [3],
  output logic [DataWidth:0]  quo_o [3]
);

  logic                valid_q;
  lsv_tag_t            tag_q;
  logic [RemWidth-1:0] den_q;
  logic [RemWidth-1:0] rem_q [3];
  logic [RemWidth-1:0] rem_d [3];
  logic [DataWidth:0]  quo_q [3];
  logic [DataWidth:0]  quo_d [3];
  logic [RemWidth-1:0] den_sh;

  assign den_sh = den_i << Shift;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo_d[k] = quo_i[k];
      rem_d[k] = rem_i[k];
      if (rem_i[k] >= den_sh) begin
        rem_d[k]        = rem_i[k] - den_sh;
        quo_d[k][Shift] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_i;
    den_q <= den_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

@@ hw/rtl/linear_solve_3x3.sv @@
// linear_solve_3x3: Cramer's rule solver for one 3x3 system per item.
// Throughput: one item per cycle; busy_o is never raised.
// The divider (one quotient bit per stage) sets the depth.
// Reset (asynchronous, active low) clears the valid bits only.
module linear_solve_3x3 import lsv_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] a00_i,
  input  logic signed [DATA_WIDTH-1:0] a01_i,
  input  logic signed [DATA_WIDTH-1:0] a02_i,
  input  logic signed [DATA_WIDTH-1:0] a10_i,
  input  logic signed [DATA_WIDTH-1:0] a11_i,
  input  logic signed [DATA_WIDTH-1:0] a12_i,
  input  logic signed [DATA_WIDTH-1:0] a20_i,
  input  logic signed [DATA_WIDTH-1:0] a21_i,
  input  logic signed [DATA_WIDTH-1:0] a22_i,
  input  logic signed [DATA_WIDTH-1:0] rhs_x_i,
  input  logic signed [DATA_WIDTH-1:0] rhs_y_i,
  input  logic signed [DATA_WIDTH-1:0] rhs_z_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] sol_x_o,
  output logic signed [DATA_WIDTH-1:0] sol_y_o,
  output logic signed [DATA_WIDTH-1:0] sol_z_o,
  output logic [1:0]                   status_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;          // 2x2 product
  localparam int CW = 2 * W + 1;      // cofactor, partial product
  localparam int DW = 3 * W + 3;      // determinant and numerators
  localparam int RW = DW + W + FRAC_BITS + 4;
  localparam int NS = W + 1;          // divider steps

  logic signed [W-1:0] m [3][3];
  logic signed [W-1:0] rhs [3];

  assign m[0][0] = a00_i; assign m[0][1] = a01_i; assign m[0][2] = a02_i;
  assign m[1][0] = a10_i; assign m[1][1] = a11_i; assign m[1][2] = a12_i;
  assign m[2][0] = a20_i; assign m[2][1] = a21_i; assign m[2][2] = a22_i;
  assign rhs[0] = rhs_x_i; assign rhs[1] = rhs_y_i; assign rhs[2] = rhs_z_i;

  logic in_fire;
  assign busy_o  = 1'b0;
  assign in_fire = start_i & ~busy_o;

  // valid bits for the arithmetic front (stages 1 to 6)
  logic [5:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], in_fire};
    end
  end

  // stage 1: 2x2 products
  logic signed [PW-1:0] pa_q [3][3];
  logic signed [PW-1:0] pb_q [3][3];
  logic signed [W-1:0]  e1_q [3];
  logic signed [W-1:0]  r1_q [3];
  logic signed [W-1:0]  e2_q [3];
  logic signed [W-1:0]  r2_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R0 = (r == 0) ? 1 : 0;
      localparam int R1 = (r == 2) ? 1 : 2;
      localparam int C0 = (c == 0) ? 1 : 0;
      localparam int C1 = (c == 2) ? 1 : 2;
      always_ff @(posedge clk_i) begin
        pa_q[r][c] <= PW'(m[R0][C0]) * PW'(m[R1][C1]);
        pb_q[r][c] <= PW'(m[R0][C1]) * PW'(m[R1][C0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      e1_q[c] <= m[0][c];
      r1_q[c] <= rhs[c];
      e2_q[c] <= e1_q[c];
      r2_q[c] <= r1_q[c];
    end
  end

  // stage 2: signed cofactors
  logic signed [CW-1:0] cof_q [3][3];
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (((r + c) % 2) == 1) begin
          cof_q[r][c] <= CW'(pb_q[r][c]) - CW'(pa_q[r][c]);
        end else begin
          cof_q[r][c] <= CW'(pa_q[r][c]) - CW'(pb_q[r][c]);
        end
      end
    end
  end

  // stage 3: factor times cofactor, split in low and high halves
  // sum 0 is the determinant, sums 1..3 the numerators
  logic signed [CW-1:0] plo_q [4][3];
  logic signed [CW-1:0] phi_q [4][3];
  for (genvar k = 0; k < 4; k++) begin : g_sum
    for (genvar t = 0; t < 3; t++) begin : g_term
      logic signed [W-1:0]  fac;
      logic signed [CW-1:0] cf;
      if (k == 0) begin : g_det
        assign fac = e2_q[t];
        assign cf  = cof_q[0][t];
      end else begin : g_num
        assign fac = r2_q[t];
        assign cf  = cof_q[t][k-1];
      end
      always_ff @(posedge clk_i) begin
        plo_q[k][t] <= CW'(fac) * CW'($signed({1'b0, cf[W-1:0]}));
        phi_q[k][t] <= CW'(fac) * CW'($signed(cf[CW-1:W]));
      end
    end
  end

  // stage 4: recombine halves; stage 5: sum of three terms
  logic signed [DW-1:0] term_q [4][3];
  logic signed [DW-1:0] sum_q  [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 3; t++) begin
        term_q[k][t] <= (DW'(phi_q[k][t]) <<< W) + DW'(plo_q[k][t]);
      end
      sum_q[k] <= term_q[k][0] + term_q[k][1] + term_q[k][2];
    end
  end

  // stage 6: magnitudes and rounding offset, n2 = |N|*2^(F+1) + |D|, d2 = 2|D|
  logic [DW-1:0] abs_d;
  logic [DW-1:0] abs_n [3];
  always_comb begin
    abs_d = sum_q[0][DW-1] ? DW'(-sum_q[0]) : DW'(sum_q[0]);
    for (int k = 0; k < 3; k++) begin
      abs_n[k] = sum_q[k+1][DW-1] ? DW'(-sum_q[k+1]) : DW'(sum_q[k+1]);
    end
  end

  lsv_tag_t      tag_w [NS+1];
  logic          dv_w  [NS+1];
  logic [RW-1:0] den_w [NS+1];
  logic [RW-1:0] rem_w [NS+1][3];
  logic [W:0]    quo_w [NS+1][3];

  lsv_tag_t      prep_tag_q;
  logic [RW-1:0] prep_den_q;
  logic [RW-1:0] prep_rem_q [3];

  always_ff @(posedge clk_i) begin
    prep_tag_q.zero <= (sum_q[0] == '0);
    prep_den_q      <= RW'(abs_d) << 1;
    for (int k = 0; k < 3; k++) begin
      prep_tag_q.neg[k] <= sum_q[k+1][DW-1] ^ sum_q[0][DW-1];
      prep_rem_q[k]     <= (RW'(abs_n[k]) << (FRAC_BITS + 1)) + RW'(abs_d);
    end
  end

  assign dv_w[0]  = vld_q[5];
  assign tag_w[0] = prep_tag_q;
  assign den_w[0] = prep_den_q;
  for (genvar k = 0; k < 3; k++) begin : g_seed
    assign rem_w[0][k] = prep_rem_q[k];
    assign quo_w[0][k] = '0;
  end

  // divider: quotient bit W first; a set top bit means the quotient overflows
  for (genvar j = 0; j < NS; j++) begin : g_div
    lsv_div_step #(
      .DataWidth (W),
      .RemWidth  (RW),
      .Shift     (W - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_w[j]),
      .tag_i   (tag_w[j]),
      .den_i   (den_w[j]),
      .rem_i   (rem_w[j]),
      .quo_i   (quo_w[j]),
      .valid_o (dv_w[j+1]),
      .tag_o   (tag_w[j+1]),
      .den_o   (den_w[j+1]),
      .rem_o   (rem_w[j+1]),
      .quo_o   (quo_w[j+1])
    );
  end

  // output stage: sign, saturation, singular override
  logic [W:0]   lim   [3];
  logic [W-1:0] res_d [3];
  logic [2:0]   sat_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim[k] = ((W + 1)'(1) << (W - 1)) - (W + 1)'(!tag_w[NS].neg[k]);
      sat_d[k] = quo_w[NS][k] > lim[k];
      if (sat_d[k]) begin
        res_d[k] = tag_w[NS].neg[k] ? W'(-lim[k]) : W'(lim[k]);
      end else begin
        res_d[k] = tag_w[NS].neg[k] ? W'(-quo_w[NS][k]) : W'(quo_w[NS][k]);
      end
    end
  end

  logic          out_vld_q;
  logic [W-1:0]  sol_q [3];
  lsv_status_t   status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_w[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_w[NS].zero) begin
      for (int k = 0; k < 3; k++) sol_q[k] <= '0;
      status_q <= ST_SINGULAR;
    end else begin
      for (int k = 0; k < 3; k++) sol_q[k] <= res_d[k];
      status_q <= (sat_d != '0) ? ST_SAT : ST_OK;
    end
  end

  assign valid_o  = out_vld_q;
  assign sol_x_o  = sol_q[0];
  assign sol_y_o  = sol_q[1];
  assign sol_z_o  = sol_q[2];
  assign status_o = status_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK || status_o == ST_SINGULAR || status_o == ST_SAT))
    else $error("bad status code");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_SINGULAR) |->
      (sol_x_o == '0 && sol_y_o == '0 && sol_z_o == '0))
    else $error("singular item with non-zero solution");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_w[NS] |=> valid_o)
    else $error("item lost at output stage");

  a_front_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |=> dv_w[1])
    else $error("item lost entering divider");

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for linear_solve_3x3 (Cramer's rule, Q16.16).
// Depends on lsv_pkg and the linear_solve_3x3 RTL; a scoreboard class predicts each solve.
module tb import lsv_pkg::*; ();

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 8;
  localparam int N_RAND = 1300;

  typedef struct {
    logic signed [DW-1:0] a [9];
    logic signed [DW-1:0] v [3];
  } system_t;

  typedef struct {
    logic signed [DW-1:0] x, y, z;
    lsv_status_t st;
  } solution_t;

  class solve_scoreboard;
    solution_t pending[$];
    int errors;
    int n_singular, n_sat, n_ok;

    function automatic logic signed [199:0] det3(logic signed [DW-1:0] m [9]);
      logic signed [199:0] r;
      r = 200'(m[0]) * (200'(m[4]) * 200'(m[8]) - 200'(m[5]) * 200'(m[7]))
        - 200'(m[1]) * (200'(m[3]) * 200'(m[8]) - 200'(m[5]) * 200'(m[6]))
        + 200'(m[2]) * (200'(m[3]) * 200'(m[7]) - 200'(m[4]) * 200'(m[6]));
      return r;
    endfunction

    // round half away from zero, then clamp
    function automatic logic signed [DW-1:0] divide(logic signed [199:0] num,
        logic signed [199:0] den, ref bit sat);
      logic [199:0] an, ad, q, lim;
      bit neg;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = ((an << (FB + 1)) + ad) / (ad << 1);
      lim = (200'd1 << (DW - 1)) - (neg ? 0 : 1);
      if (q > lim) begin
        q = lim;
        sat = 1;
      end
      if (neg) q = -q;
      return q[DW-1:0];
    endfunction

    function void note_item(system_t s);
      logic signed [199:0] d, n;
      logic signed [DW-1:0] t [9];
      logic signed [DW-1:0] c [3];
      solution_t e;
      bit sat;
      sat = 0;
      d = det3(s.a);
      if (d == 0) begin
        e = '{0, 0, 0, ST_SINGULAR};
        n_singular++;
      end else begin
        for (int col = 0; col < 3; col++) begin
          t = s.a;
          for (int r = 0; r < 3; r++) t[3*r + col] = s.v[r];
          n = det3(t);
          c[col] = divide(n, d, sat);
        end
        e = '{c[0], c[1], c[2], sat ? ST_SAT : ST_OK};
        if (sat) n_sat++; else n_ok++;
      end
      pending.push_back(e);
    endfunction

    function void check_result(solution_t g);
      solution_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.x !== e.x) begin $error("sol_x exp %h got %h", e.x, g.x); errors++; end
      if (g.y !== e.y) begin $error("sol_y exp %h got %h", e.y, g.y); errors++; end
      if (g.z !== e.z) begin $error("sol_z exp %h got %h", e.z, g.z); errors++; end
      if (g.st !== e.st) begin $error("status exp %0d got %0d", e.st, g.st); errors++; end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o, valid_o;
  logic signed [DW-1:0] a_q [9];
  logic signed [DW-1:0] v_q [3];
  logic signed [DW-1:0] sol_x_o, sol_y_o, sol_z_o;
  logic [1:0] status_o;

  solve_scoreboard sb = new();

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    for (int i = 0; i < 9; i++) a_q[i] = '0;
    for (int i = 0; i < 3; i++) v_q[i] = '0;
  end

  linear_solve_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .a00_i(a_q[0]), .a01_i(a_q[1]), .a02_i(a_q[2]),
    .a10_i(a_q[3]), .a11_i(a_q[4]), .a12_i(a_q[5]),
    .a20_i(a_q[6]), .a21_i(a_q[7]), .a22_i(a_q[8]),
    .rhs_x_i(v_q[0]), .rhs_y_i(v_q[1]), .rhs_z_i(v_q[2]),
    .valid_o, .sol_x_o, .sol_y_o, .sol_z_o, .status_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result('{sol_x_o, sol_y_o, sol_z_o, status_o});
  end

  // holds start until the item is taken; the next item may follow back to back
  task automatic send_item(system_t s, int gap);
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    a_q <= s.a;
    v_q <= s.v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(s);
  endtask

  function automatic logic signed [DW-1:0] rand_val(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      2: return $signed($urandom_range(0, 512)) - 256;
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b0, {(DW-1){1'b1}}};
          1: return {1'b1, {(DW-1){1'b0}}};
          2: return 0;
          3: return 1 << FB;
          default: return -(1 << FB);
        endcase
      end
    endcase
  endfunction

  function automatic system_t rand_system();
    system_t s;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) s.a[i] = rand_val(k < 2 ? 0 : k < 6 ? 1 : k < 8 ? 2 : 3);
    for (int i = 0; i < 3; i++) s.v[i] = rand_val(k < 2 ? 0 : k < 6 ? 1 : k < 8 ? 2 : 3);
    // force singular: copy one row onto another, sometimes scaled by -1
    if ($urandom_range(0, 9) == 0)
      for (int c = 0; c < 3; c++) s.a[3 + c] = ($urandom_range(0, 1)) ? s.a[c] : -s.a[c];
    return s;
  endfunction

  function automatic system_t diag_system(logic signed [DW-1:0] d, logic signed [DW-1:0] r);
    system_t s;
    for (int i = 0; i < 9; i++) s.a[i] = 0;
    s.a[0] = d; s.a[4] = d; s.a[8] = d;
    s.v = '{r, -r, r};
    return s;
  endfunction

  initial begin
    system_t s;
    logic signed [DW-1:0] mx, mn;
    int timeout;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identity, extremes, singular, saturation, rounding ties
    send_item(diag_system(1 << FB, 3 << FB), 0);
    send_item(diag_system(1 << FB, mx), 0);
    send_item(diag_system(1 << FB, mn), 0);
    send_item(diag_system(0, 1 << FB), 0);
    send_item(diag_system(1, mx), 0);
    send_item(diag_system(1, mn), 0);
    send_item(diag_system(mx, mx), 1);
    send_item(diag_system(mn, mn), 0);
    send_item(diag_system(mn, mx), 0);
    send_item(diag_system(2 << FB, 1), 0);
    send_item(diag_system(-(2 << FB), 3), 0);
    send_item(diag_system(-1, 1), 0);
    for (int i = 0; i < 9; i++) s.a[i] = mx;
    s.v = '{mn, mx, 0};
    send_item(s, 0);
    for (int i = 0; i < 9; i++) s.a[i] = mn;
    send_item(s, 2);
    for (int i = 0; i < 9; i++) s.a[i] = (i % 4 == 0) ? mn : mx;
    s.v = '{mx, mn, -1};
    send_item(s, 0);
    for (int i = 0; i < 9; i++) s.a[i] = -1;
    s.a[0] = 0; s.a[4] = 0; s.a[8] = 0;
    send_item(s, 0);

    for (int n = 0; n < N_RAND; n++)
      send_item(rand_system(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0);
    start_i <= 0;

    timeout = 0;
    while (sb.pending.size() != 0 && timeout < 10 * LATENCY) begin
      @(posedge clk_i);
      timeout++;
    end
    repeat (LATENCY) @(posedge clk_i);
    $display("tb: %0d solves ok, %0d saturated, %0d singular",
             sb.n_ok, sb.n_sat, sb.n_singular);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
